// File: rtl/core/pwl_pkg.sv
// Package: shared constants and types for the piecewise linear evaluator.
package pwl_pkg;

    localparam int MAX_POINTS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DATA_W            = 32;
    localparam int CNT_W             = 5;
    localparam int IDX_W             = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_SLOPE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREV,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // Request from the controller to the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [33:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/core/pwl_div.sv
// Module: unsigned restoring divider, one quotient bit per cycle.
module pwl_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pwl_pkg::div_req_t  req,
    output pwl_pkg::div_rsp_t  rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [34:0] rem_reg, rem_next;
    logic [33:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] trial;
    logic [34:0] diff;

    // Shift one dividend bit into the remainder and try a subtract.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[33:0], quo_reg[63]};
        diff      = trial - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[34])
            begin
                rem_next = diff;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == 7'd63) |=> done_reg)
        else $error("divider missed its last step");

endmodule

// File: rtl/core/piecewise_linear_eval.sv
// Top level: piecewise linear function evaluator over a breakpoint table.
//
// A write word stores one breakpoint (date, value) and gives no result. An
// evaluate word walks the breakpoint memory one slot per cycle (the next
// address issued while the current slot is compared), so the scan reads at
// most point_count slots (capped at MAX_POINTS). Exact value hits,
// out-of-range times and a single-point slope finish right after the scan;
// an empty table finishes without a scan. A hit inside the table then fetches
// the neighbor slot (twice for a forward slope), multiplies in value mode and
// runs the 64-step shift-subtract divider; the divider sets the rate. One word
// is worked on at a time; a finished result waits in the output register
// while the next word is accepted, and the block holds in its last state only
// when a second result is ready before the first one is taken.
module piecewise_linear_eval
#(
    parameter int MAX_POINTS    = pwl_pkg::MAX_POINTS_DEF,
    parameter int FRACTION_BITS = pwl_pkg::FRACTION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: point_count[4:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    // s_tdata: command[1:0], point_index[5:2], point_date[37:6],
    //          point_value[69:38], query_time[101:70]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,
    // m_tdata: result_value[31:0], status[33:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW = AW + 1;

    // Breakpoint memory: date and value side by side.
    logic [63:0] mem [MAX_POINTS];
    logic [63:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic [4:0]  count_reg;
    logic [SW-1:0] n_reg, n_next;
    pwl_pkg::state_t state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;      // slot whose data is in rd_reg
    logic        mode_reg, mode_next;      // 1: slope
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] xb_reg, xb_next, yb_reg, yb_next;
    logic        dvneg_reg, dvneg_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    logic        ov_reg, ov_next;
    logic [63:0] prod_reg, prod_next;
    logic [33:0] dmag_reg, dmag_next;      // |dy| or |dt|
    logic [33:0] xmag_reg, xmag_next;      // |dx|
    logic signed [31:0] ya_reg, ya_next;
    logic        neg_reg, neg_next;
    logic        prod_pend_reg, prod_pend_next;

    pwl_pkg::div_req_t dreq;
    pwl_pkg::div_rsp_t drsp;

    logic [1:0]   in_cmd;
    logic [3:0]   in_idx;
    logic [31:0]  in_date, in_val, in_time;
    logic signed [31:0] rd_date, rd_val;
    logic         accept;
    logic         out_load;

    assign in_cmd  = s_tdata[1:0];
    assign in_idx  = s_tdata[5:2];
    assign in_date = s_tdata[37:6];
    assign in_val  = s_tdata[69:38];
    assign in_time = s_tdata[101:70];
    assign rd_date = rd_reg[31:0];
    assign rd_val  = rd_reg[63:32];

    assign s_tready  = (state_reg == pwl_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign wr_en     = accept && (in_cmd == pwl_pkg::CMD_WRITE)
                       && (int'(in_idx) < MAX_POINTS);
    // Load the output register when it is empty or being drained.
    assign out_load  = (state_reg == pwl_pkg::S_DONE) && (!m_tvalid || m_tready);

    // Memory port: one write and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(in_idx)] <= {in_val, in_date};
        rd_reg <= mem[rd_addr];
    end

    logic signed [33:0] dx, dy, dt;
    logic [33:0] dxm, dym, dtm;
    logic [63:0] qsat;
    logic signed [34:0] sum;
    logic [33:0] qmag;

    always_comb
    begin
        dx  = 34'(xb_reg) - 34'(rd_date);
        dy  = 34'(yb_reg) - 34'(rd_val);
        dt  = 34'(t_reg)  - 34'(rd_date);
        dxm = dx[33] ? -dx : dx;
        dym = dy[33] ? -dy : dy;
        dtm = dt[33] ? -dt : dt;
        qmag = (drsp.quotient > 64'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF
               : drsp.quotient[33:0];
        qsat = 64'(qmag);
        sum  = 35'(ya_reg) + (neg_reg ? -35'(qmag) : 35'(qmag));
    end

    // Sequencer: scan, fetch neighbor slot, multiply, divide, deliver.
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        mode_next = mode_reg;
        t_next = t_reg;
        xb_next = xb_reg;
        yb_next = yb_reg;
        dvneg_next = dvneg_reg;
        res_next = res_reg;
        st_next = st_reg;
        ov_next = ov_reg;
        prod_next = prod_reg;
        dmag_next = dmag_reg;
        xmag_next = xmag_reg;
        ya_next = ya_reg;
        neg_next = neg_reg;
        prod_pend_next = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        dreq.start = 1'b0;
        dreq.dividend = prod_reg;
        dreq.divisor = xmag_reg;
        unique case (state_reg)
            pwl_pkg::S_IDLE:
            begin
                rd_addr = '0;
                if (accept && (in_cmd == pwl_pkg::CMD_VALUE
                               || in_cmd == pwl_pkg::CMD_SLOPE))
                begin
                    mode_next = (in_cmd == pwl_pkg::CMD_SLOPE);
                    t_next = in_time;
                    res_next = '0;
                    st_next = pwl_pkg::ST_OK;
                    idx_next = '0;
                    n_next = (int'(count_reg) > MAX_POINTS) ? SW'(MAX_POINTS)
                             : SW'(count_reg);
                    if (count_reg == 5'd0)
                    begin
                        st_next = pwl_pkg::ST_EMPTY;
                        state_next = pwl_pkg::S_DONE;
                    end
                    else
                        state_next = pwl_pkg::S_SCAN;
                end
            end
            pwl_pkg::S_SCAN:
            begin
                rd_addr = AW'(idx_reg + SW'(1));
                if (rd_date == t_reg && !mode_reg)
                begin
                    res_next = rd_val;
                    state_next = pwl_pkg::S_DONE;
                end
                else if (rd_date == t_reg)
                begin
                    if (idx_reg + SW'(1) < n_reg)
                    begin
                        // slope forward: current becomes a, fetch b
                        xb_next = rd_date;
                        yb_next = rd_val;
                        idx_next = idx_reg + SW'(1);
                        ov_next = 1'b1;
                        state_next = pwl_pkg::S_PREV;
                    end
                    else if (idx_reg != '0)
                    begin
                        xb_next = rd_date;
                        yb_next = rd_val;
                        rd_addr = AW'(idx_reg - SW'(1));
                        ov_next = 1'b0;
                        state_next = pwl_pkg::S_PREV;
                    end
                    else
                        state_next = pwl_pkg::S_DONE;
                end
                else if (rd_date > t_reg)
                begin
                    if (idx_reg == '0)
                        state_next = pwl_pkg::S_DONE;
                    else
                    begin
                        xb_next = rd_date;
                        yb_next = rd_val;
                        rd_addr = AW'(idx_reg - SW'(1));
                        ov_next = 1'b0;
                        state_next = pwl_pkg::S_PREV;
                    end
                end
                else if (idx_reg + SW'(1) >= n_reg)
                    state_next = pwl_pkg::S_DONE;
                else
                    idx_next = idx_reg + SW'(1);
            end
            pwl_pkg::S_PREV:
            begin
                if (ov_reg)
                begin
                    // forward slope: rd holds b, xb/yb hold a; swap roles
                    xb_next = rd_date;
                    yb_next = rd_val;
                    ov_next = 1'b0;
                    rd_addr = AW'(idx_reg - SW'(1));
                end
                else if (dx == '0)
                begin
                    st_next = pwl_pkg::ST_ZERO;
                    state_next = pwl_pkg::S_DONE;
                end
                else
                begin
                    xmag_next = dxm;
                    ya_next = rd_val;
                    if (mode_reg)
                    begin
                        dmag_next = dym;
                        neg_next = dx[33] != dy[33];
                        prod_next = 64'(dym) << FRACTION_BITS;
                        state_next = pwl_pkg::S_DIV;
                        prod_pend_next = 1'b1;
                        ya_next = '0;
                    end
                    else
                    begin
                        dmag_next = dtm;
                        xb_next = dym[31:0];
                        dvneg_next = dym[32];
                        neg_next = (dt[33] != dy[33]) != dx[33];
                        state_next = pwl_pkg::S_MUL;
                    end
                end
            end
            pwl_pkg::S_MUL:
            begin
                // |dt| * |dy|, both under 2^33
                prod_next = 64'(dmag_reg) * 64'({dvneg_reg, xb_reg});
                prod_pend_next = 1'b1;
                state_next = pwl_pkg::S_DIV;
            end
            pwl_pkg::S_DIV:
            begin
                if (prod_pend_reg)
                    dreq.start = 1'b1;
                else if (drsp.done)
                begin
                    if (qsat == '0)
                        neg_next = 1'b0;
                    if (mode_reg)
                        res_next = (qmag > 34'h7FFF_FFFF && !neg_reg) ? 32'h7FFF_FFFF
                                 : (qmag > 34'h8000_0000) ? 32'h8000_0000
                                 : neg_reg ? 32'(-qmag) : qmag[31:0];
                    else
                        res_next = (sum > 35'sh7FFF_FFFF) ? 32'h7FFF_FFFF
                                 : (sum < -35'sh8000_0000) ? 32'h8000_0000
                                 : sum[31:0];
                    state_next = pwl_pkg::S_DONE;
                end
            end
            pwl_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (out_load)
                    state_next = pwl_pkg::S_IDLE;
            end
            default:
                state_next = pwl_pkg::S_IDLE;
        endcase
    end

    pwl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwl_pkg::S_IDLE;
            count_reg     <= '0;
            m_tvalid      <= 1'b0;
            prod_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_pend_reg <= prod_pend_next;
            if (cfg_valid)
                count_reg <= cfg_data[4:0];
            if (out_load)
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        mode_reg  <= mode_next;
        t_reg     <= t_next;
        xb_reg    <= xb_next;
        yb_reg    <= yb_next;
        dvneg_reg <= dvneg_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        ov_reg    <= ov_next;
        prod_reg  <= prod_next;
        dmag_reg  <= dmag_next;
        xmag_reg  <= xmag_next;
        ya_reg    <= ya_next;
        neg_reg   <= neg_next;
        if (out_load)
            m_tdata <= {6'd0, st_reg, res_reg};
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pwl_pkg::S_IDLE) |-> !s_tready)
        else $error("accept while busy");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pwl_pkg::S_DONE) |=> m_tvalid)
        else $error("result lost");
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> state_reg == pwl_pkg::S_DIV)
        else $error("divider runs outside divide state");

endmodule

// File: verif/piecewise_linear_eval_checker.sv
// Checker for the piecewise linear evaluator: predicts each result and compares.
`timescale 1ns / 1ps

module piecewise_linear_eval_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic [31:0]      result_value;
        pwl_pkg::status_t status;
    } eval_result_t;

    logic signed [31:0] dates [pwl_pkg::MAX_POINTS_DEF];
    logic signed [31:0] values [pwl_pkg::MAX_POINTS_DEF];
    logic [4:0]         npoints;
    eval_result_t       expected_results [$];

    assign pending_count = expected_results.size();

    // Clamp a signed 64-bit value into the 32-bit range.
    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint bound_mag(input logic [63:0] m, input bit neg);
        logic [63:0] c;
        c = (m > 64'd17179869184) ? 64'd17179869184 : m;
        return neg ? -longint'(c) : longint'(c);
    endfunction

    function automatic logic [63:0] absval(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Slope of the segment between two slots; status set on zero width.
    function automatic eval_result_t segment_slope(input int a, input int b);
        eval_result_t r;
        longint dx, dy;
        logic [63:0] q;
        dx = longint'(dates[b]) - longint'(dates[a]);
        dy = longint'(values[b]) - longint'(values[a]);
        r.status = pwl_pkg::ST_OK;
        r.result_value = '0;
        if (dx == 0)
        begin
            r.status = pwl_pkg::ST_ZERO;
            return r;
        end
        q = (absval(dy) << pwl_pkg::FRACTION_BITS_DEF) / absval(dx);
        r.result_value = clip32(bound_mag(q, (dx < 0) != (dy < 0)));
        return r;
    endfunction

    function automatic eval_result_t segment_interp(input int a, input int b,
                                                    input logic signed [31:0] t);
        eval_result_t r;
        longint dx, dy, dt;
        logic [63:0] q;
        bit neg;
        dx = longint'(dates[b]) - longint'(dates[a]);
        dy = longint'(values[b]) - longint'(values[a]);
        dt = longint'(t) - longint'(dates[a]);
        r.status = pwl_pkg::ST_OK;
        r.result_value = '0;
        if (dx == 0)
        begin
            r.status = pwl_pkg::ST_ZERO;
            return r;
        end
        q = (absval(dt) * absval(dy)) / absval(dx);
        neg = ((dt < 0) != (dy < 0)) != (dx < 0);
        if (q == 0)
            neg = 0;
        r.result_value = clip32(longint'(values[a]) + bound_mag(q, neg));
        return r;
    endfunction

    // Walk the table the way the block does and return the answer.
    function automatic eval_result_t evaluate_query(input pwl_pkg::cmd_t cmd,
                                                    input logic signed [31:0] t);
        eval_result_t r;
        int n;
        r.result_value = '0;
        r.status = pwl_pkg::ST_OK;
        n = (npoints > pwl_pkg::MAX_POINTS_DEF) ? pwl_pkg::MAX_POINTS_DEF : npoints;
        if (n == 0)
        begin
            r.status = pwl_pkg::ST_EMPTY;
            return r;
        end
        for (int i = 0; i < n; i++)
        begin
            if (dates[i] == t)
            begin
                if (cmd == pwl_pkg::CMD_VALUE)
                    r.result_value = values[i];
                else if (i + 1 < n)
                    r = segment_slope(i, i + 1);
                else if (i > 0)
                    r = segment_slope(i - 1, i);
                return r;
            end
            if (dates[i] > t)
            begin
                if (i > 0)
                    r = (cmd == pwl_pkg::CMD_VALUE) ? segment_interp(i - 1, i, t)
                                                    : segment_slope(i - 1, i);
                return r;
            end
        end
        return r;
    endfunction

    // Track configuration and inputs, then compare outputs in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npoints <= '0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            eval_result_t exp_r;
            pwl_pkg::cmd_t cmd;
            if (cfg_valid && cfg_ready)
                npoints <= cfg_data[4:0];
            if (s_tvalid && s_tready)
            begin
                cmd = pwl_pkg::cmd_t'(s_tdata[1:0]);
                if (cmd == pwl_pkg::CMD_WRITE)
                begin
                    dates[s_tdata[5:2]] = s_tdata[37:6];
                    values[s_tdata[5:2]] = s_tdata[69:38];
                end
                else if (cmd != pwl_pkg::CMD_NONE)
                    expected_results.push_back(evaluate_query(cmd, s_tdata[101:70]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[31:0] !== exp_r.result_value)
                    begin
                        $error("result_value expected %h actual %h",
                               exp_r.result_value, m_tdata[31:0]);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_tdata[33:32] !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d",
                               exp_r.status, m_tdata[33:32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/piecewise_linear_eval_test.sv
// Testbench top for the piecewise linear evaluator: stimulus and verdict.
`timescale 1ns / 1ps

module piecewise_linear_eval_test;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;
    int           cycle_count;
    logic signed [31:0] table_dates [16];
    int           loaded_points;

    piecewise_linear_eval u_top (.*);

    piecewise_linear_eval_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit guard.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 900000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stall, plus a long hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one word and wait for its acceptance; valid stays high until an idle draw or wait_idle drops it.
    task automatic send_word(input pwl_pkg::cmd_t cmd, input logic [3:0] idx,
                             input logic [31:0] pdate, input logic [31:0] pval,
                             input logic [31:0] qtime);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, qtime, pval, pdate, idx, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid, drain all expected results, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_count(input logic [7:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load n ascending breakpoints, with an occasional repeated date.
    task automatic load_table(input int n, input bit wide);
        logic signed [31:0] d;
        int step_max;
        step_max = wide ? 32'h0fff_ffff : 32'h0003_0000;
        d = wide ? 32'h8000_0000 + $urandom_range(1000) : $urandom_range(20) * 32'h1_0000
            - 32'h8_0000;
        for (int i = 0; i < n; i++)
        begin
            table_dates[i] = d;
            send_word(pwl_pkg::CMD_WRITE, i[3:0], d,
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h40000)
                      - 32'h20000, $urandom);
            if ($urandom_range(9) != 0)
                d = d + $urandom_range(step_max, 1);
        end
        loaded_points = n;
    endtask

    // Query time: mostly at or near breakpoints, sometimes anything.
    function automatic logic [31:0] pick_time();
        int k;
        k = $urandom_range(loaded_points - 1);
        case ($urandom_range(3))
            0: return table_dates[k];
            1: return table_dates[k] + $urandom_range(32'h2_0000) - 32'h1_0000;
            2: return $urandom;
            default: return table_dates[k] - 1;
        endcase
    endfunction

    // Load a table, set its count (oversized only over a full table), query.
    task automatic random_phase(input int queries);
        int n;
        n = ($urandom_range(3) == 0) ? 16 : int'($urandom_range(8, 1));
        load_table(n, $urandom_range(1) == 1);
        wait_idle();
        if (n == 16 && $urandom_range(3) == 0)
            write_count(8'd31);
        else
            write_count(8'(n));
        for (int j = 0; j < queries; j++)
            send_word(($urandom_range(1) == 0) ? pwl_pkg::CMD_VALUE : pwl_pkg::CMD_SLOPE,
                      4'($urandom), $urandom, $urandom, pick_time());
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        loaded_points = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, then extremes and special cases.
        send_word(pwl_pkg::CMD_VALUE, 4'd0, '0, '0, 32'h8000_0000);
        send_word(pwl_pkg::CMD_SLOPE, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        send_word(pwl_pkg::CMD_WRITE, 4'd0, 32'h8000_0000, 32'h7fff_ffff, '0);
        send_word(pwl_pkg::CMD_WRITE, 4'd1, 32'h8000_0001, 32'h8000_0000, '0);
        send_word(pwl_pkg::CMD_WRITE, 4'd2, 32'h8000_0001, 32'h0001_0000, '0);
        send_word(pwl_pkg::CMD_WRITE, 4'd3, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(pwl_pkg::CMD_NONE, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        wait_idle();
        write_count(8'd1);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, 32'h8000_0000);
        send_word(pwl_pkg::CMD_VALUE, 4'd0, '0, '0, 32'h8000_0000);
        send_word(pwl_pkg::CMD_VALUE, 4'd0, '0, '0, 32'h7fff_ffff);
        wait_idle();
        write_count(8'd4);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, 32'h8000_0000);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, 32'h8000_0001);
        send_word(pwl_pkg::CMD_VALUE, 4'd0, '0, '0, 32'h0000_0000);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, 32'h0000_0000);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, 32'h7fff_ffff);
        send_word(pwl_pkg::CMD_VALUE, 4'd0, '0, '0, 32'h7fff_ffff);
        wait_idle();
        write_count(8'd0);
        send_word(pwl_pkg::CMD_SLOPE, 4'd0, '0, '0, '0);
        wait_idle();

        // Random phases under three idling profiles.
        send_idle_pct = 17;
        recv_idle_pct = 74;
        for (int p = 0; p < 10; p++)
            random_phase(35);
        send_idle_pct = 74;
        recv_idle_pct = 17;
        for (int p = 0; p < 10; p++)
            random_phase(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 2000;
        for (int p = 0; p < 10; p++)
            random_phase(35);

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
